// ===== hw/rtl/fingerprint_uart_frame_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fingerprint UART frame parser
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FINGERPRINT_UART_FRAME_PARSER_MACROS_SVH
`define FINGERPRINT_UART_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FUP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FUP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fup_pkg.sv =====
// ----------------------------------------------------------------------------
// Fingerprint UART frame parser package
// Word types, status codes, register indexes and frame constants.
// ----------------------------------------------------------------------------
package fup_pkg;

    localparam logic [7:0] MARKER = 8'hF5;
    localparam logic [16:0] PARAM_END = 17'd6;

    localparam logic [7:0] RST_CMD_CURRENT = 8'd35;
    localparam logic [7:0] RST_CMD_BY_ID   = 8'd49;
    localparam logic [7:0] RST_ACK_SUCCESS = 8'd0;
    localparam logic [7:0] RST_ACK_TIMEOUT = 8'd8;

    typedef enum logic [2:0] {
        ST_GOOD     = 3'd0,
        ST_START    = 3'd1,
        ST_CMD      = 3'd2,
        ST_DATA     = 3'd3,
        ST_CHECK    = 3'd4,
        ST_CSUM_ERR = 3'd5,
        ST_TAIL_ERR = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CFG_CMD_CURRENT = 2'd0,
        CFG_CMD_BY_ID   = 2'd1,
        CFG_ACK_SUCCESS = 2'd2,
        CFG_ACK_TIMEOUT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] cmd_current;
        logic [7:0] cmd_by_id;
        logic [7:0] ack_ok;
        logic [7:0] ack_tmo;
    } t_cfg;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic        frame_mode;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_command;
        logic [7:0]  param_high;
        logic [7:0]  param_low;
        logic [7:0]  ack_value;
        logic [15:0] data_length;
        logic        data_pending;
    } t_res_word;

endpackage

// ===== hw/rtl/fup_word_if.sv =====
// ----------------------------------------------------------------------------
// Word channel interface
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface fup_word_if #(
    parameter type t_data = logic [7:0]
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fup_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration register bank
// Holds the feature command codes and the ack codes that open a data frame.
// ----------------------------------------------------------------------------
module fup_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    output fup_pkg::t_cfg     o_cfg
);
    import fup_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd_current <= RST_CMD_CURRENT;
            r_cfg.cmd_by_id   <= RST_CMD_BY_ID;
            r_cfg.ack_ok      <= RST_ACK_SUCCESS;
            r_cfg.ack_tmo     <= RST_ACK_TIMEOUT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CMD_CURRENT: r_cfg.cmd_current <= i_cfg_data;
                CFG_CMD_BY_ID:   r_cfg.cmd_by_id   <= i_cfg_data;
                CFG_ACK_SUCCESS: r_cfg.ack_ok      <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_cfg.ack_tmo     <= i_cfg_data;
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/fup_parse_core.sv =====
// ----------------------------------------------------------------------------
// Frame parse core
// Per-byte frame state machine with running XOR and latched header fields.
// ----------------------------------------------------------------------------
module fup_parse_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [7:0]         i_byte,
    input  fup_pkg::t_cfg      i_cfg,
    output fup_pkg::t_res_word o_result
);
    import fup_pkg::*;

    typedef enum logic [2:0] {
        FS_HEAD  = 3'd0,
        FS_CMD   = 3'd1,
        FS_PARA  = 3'd2,
        FS_CHECK = 3'd3,
        FS_TAIL  = 3'd4,
        FS_DATA  = 3'd5
    } t_field;

    t_field                 r_field, n_field;
    logic                   r_data_mode, n_data_mode;
    logic [16:0]            r_count, n_count;
    logic [7:0]             r_xor, n_xor;
    logic [7:0]             r_check, n_check;
    logic [7:0]             r_last_cmd, n_last_cmd;
    logic [7:0]             r_param [3];
    logic [7:0]             n_param [3];
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [7:0]             r_rx_cmd, n_rx_cmd;
    logic [7:0]             r_rx_param [3];
    logic [7:0]             n_rx_param [3];

    t_status     w_status;
    logic        w_pvalid;
    logic [7:0]  w_pbyte;
    logic [15:0] w_pindex;
    logic [16:0] w_count_inc;
    logic [16:0] w_len_end;
    logic [2:0]  w_param_k;
    logic        w_feature;

    assign w_count_inc = r_count + 17'd1;
    assign w_len_end   = 17'(r_len) + 17'd1;
    assign w_param_k   = r_count[2:0] - 3'd2;
    assign w_feature   = (r_rx_cmd == i_cfg.cmd_current || r_rx_cmd == i_cfg.cmd_by_id) &&
                         (r_rx_param[2] == i_cfg.ack_ok ||
                          r_rx_param[2] == i_cfg.ack_tmo);

    always_comb begin
        n_field     = r_field;
        n_data_mode = r_data_mode;
        n_count     = r_count;
        n_xor       = r_xor;
        n_check     = r_check;
        n_last_cmd  = r_last_cmd;
        n_param     = r_param;
        n_len       = r_len;
        n_rx_cmd    = r_rx_cmd;
        n_rx_param  = r_rx_param;
        w_status    = ST_START;
        w_pvalid    = 1'b0;
        w_pbyte     = 8'd0;
        w_pindex    = 16'd0;

        case (r_field)
            FS_HEAD: begin
                if (i_byte == MARKER) begin
                    n_count = 17'd1;
                    n_xor   = 8'd0;
                    if (!r_data_mode) begin
                        n_field = FS_CMD;
                    end else begin
                        n_field = (r_len != '0) ? FS_DATA : FS_CHECK;
                    end
                end
            end
            FS_CMD: begin
                n_rx_cmd = i_byte;
                n_xor    = r_xor ^ i_byte;
                n_count  = 17'd2;
                n_field  = FS_PARA;
                w_status = ST_CMD;
            end
            FS_PARA: begin
                if (w_param_k < 3'd3) begin
                    n_rx_param[w_param_k[1:0]] = i_byte;
                end
                n_xor   = r_xor ^ i_byte;
                n_count = w_count_inc;
                if (w_count_inc >= PARAM_END) begin
                    n_field = FS_CHECK;
                end
                w_status = ST_DATA;
            end
            FS_DATA: begin
                w_pvalid = 1'b1;
                w_pbyte  = i_byte;
                w_pindex = r_count[15:0] - 16'd1;
                n_xor    = r_xor ^ i_byte;
                n_count  = w_count_inc;
                if (w_count_inc >= w_len_end) begin
                    n_field = FS_CHECK;
                end
                w_status = ST_DATA;
            end
            FS_CHECK: begin
                n_check  = i_byte;
                n_field  = FS_TAIL;
                w_status = ST_CHECK;
            end
            FS_TAIL: begin
                if (i_byte == MARKER) begin
                    if (r_xor == r_check) begin
                        w_status = ST_GOOD;
                        if (!r_data_mode) begin
                            n_last_cmd = r_rx_cmd;
                            n_param    = r_rx_param;
                            if (w_feature) begin
                                n_len       = LENGTH_BITS'({r_rx_param[0], r_rx_param[1]});
                                n_data_mode = 1'b1;
                            end
                        end else begin
                            n_data_mode = 1'b0;
                        end
                    end else begin
                        w_status = ST_CSUM_ERR;
                    end
                end else begin
                    w_status    = ST_TAIL_ERR;
                    n_data_mode = 1'b0;
                end
                n_count = 17'd0;
                n_field = FS_HEAD;
            end
            default: begin
                n_data_mode = 1'b0;
                n_count     = 17'd0;
                n_field     = FS_HEAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field     <= FS_HEAD;
            r_data_mode <= 1'b0;
            r_count     <= 17'd0;
            r_xor       <= 8'd0;
            r_check     <= 8'd0;
            r_last_cmd  <= 8'd0;
            r_param     <= '{default: 8'd0};
            r_len       <= '0;
            r_rx_cmd    <= 8'd0;
            r_rx_param  <= '{default: 8'd0};
        end else if (i_advance) begin
            r_field     <= n_field;
            r_data_mode <= n_data_mode;
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_check     <= n_check;
            r_last_cmd  <= n_last_cmd;
            r_param     <= n_param;
            r_len       <= n_len;
            r_rx_cmd    <= n_rx_cmd;
            r_rx_param  <= n_rx_param;
        end
    end

    // The result shows the mode the byte was parsed in and the state after it.
    always_comb begin
        o_result.status        = w_status;
        o_result.frame_mode    = r_data_mode;
        o_result.payload_valid = w_pvalid;
        o_result.payload_byte  = w_pbyte;
        o_result.payload_index = w_pindex;
        o_result.frame_command = n_last_cmd;
        o_result.param_high    = n_param[0];
        o_result.param_low     = n_param[1];
        o_result.ack_value     = n_param[2];
        o_result.data_length   = 16'(n_len);
        o_result.data_pending  = n_data_mode;
    end

endmodule

// ===== hw/rtl/fingerprint_uart_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Fingerprint UART frame parser
// Deframes received serial bytes into header and data frames, one result
// word for every byte.
// ----------------------------------------------------------------------------
// Every received byte on the input channel produces exactly one result word.
// A byte is taken into an input register, decoded by the frame state machine
// and lands in a result register, from which its result word is offered;
// one byte is taken every cycle as long as the result side keeps taking
// words. The rate is set by the single state update per byte: the XOR
// accumulator and byte counter advance once per decoded byte. Header frames
// carry a command, four parameters, a check byte and a closing marker; a
// good header frame that answers a feature request loads the payload length
// and arms data mode. Payload bytes of a data frame are streamed out with
// payload_valid set and their index; the consumer keeps them only when the
// frame ends with a good status. Configuration registers are written through
// a plain write port and should only change while no byte is in flight.
module fingerprint_uart_frame_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    fup_word_if.sink   i_rx_word,
    fup_word_if.source o_res_word
);
    import fup_pkg::*;

    // Input register stage.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Result register stage.
    logic      r_out_valid;
    t_res_word r_out_word;

    t_cfg      w_cfg;
    t_res_word w_result;
    logic      w_advance;
    logic      w_in_take;

    // A byte moves from the input register into the result register whenever
    // the result register is empty or is being drained in this same cycle.
    assign w_advance = r_in_valid && (!r_out_valid || o_res_word.ready);

    // The input register takes a new byte when it is empty or emptying, so a
    // word can be accepted while a finished result still waits downstream.
    assign i_rx_word.ready = !r_in_valid || w_advance;
    assign w_in_take       = i_rx_word.valid && i_rx_word.ready;

    fup_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    fup_parse_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx_word.data.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res_word.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_word <= w_result;
        end
    end

    assign o_res_word.valid = r_out_valid;
    assign o_res_word.data  = r_out_word;

endmodule

// ===== hw/rtl/fup_checker.sv =====
// ----------------------------------------------------------------------------
// Fingerprint UART frame parser port checker
// Watches the result channel for handshake and frame status consistency.
// ----------------------------------------------------------------------------
`include "fingerprint_uart_frame_parser_macros.svh"

module fup_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input fup_pkg::t_res_word i_out_word
);
    import fup_pkg::*;

    // A stalled result word stays offered and unchanged.
    `FUP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_word), "result word changed while stalled")

    // Payload bytes only come from data frames and carry the payload status.
    `FUP_ASSERT_NOW(a_payload_mode, i_clk, i_rst_n, i_out_valid && i_out_word.payload_valid, i_out_word.frame_mode && i_out_word.status == ST_DATA, "payload byte outside data frame")

    // A command byte is only parsed in header mode.
    `FUP_ASSERT_NOW(a_cmd_header, i_clk, i_rst_n, i_out_valid && i_out_word.status == ST_CMD, !i_out_word.frame_mode, "command status in data mode")

    // A data frame that ends good or with a bad tail returns to header mode.
    `FUP_ASSERT_NOW(a_data_exit, i_clk, i_rst_n, i_out_valid && i_out_word.frame_mode && (i_out_word.status == ST_GOOD || i_out_word.status == ST_TAIL_ERR), !i_out_word.data_pending, "data mode kept after frame end")

endmodule

bind fingerprint_uart_frame_parser fup_checker u_fup_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res_word.valid),
    .i_out_ready (o_res_word.ready),
    .i_out_word  (o_res_word.data)
);
